/* sv/hht_pkg.sv */
// Shared types and constants of the HTTP header tokenizer.
package hht_pkg;

  // Width of the internal byte position counter
  localparam int unsigned PosBits = 16;
  // Width of positions and lengths on the result channel
  localparam int unsigned OutBits = 16;
  // Common width used when comparing a position with the start offset
  localparam int unsigned CmpBits = (PosBits > OutBits) ? PosBits : OutBits;

  localparam int unsigned KindBits  = 3;
  localparam int unsigned CountBits = 8;
  localparam int unsigned CfgIdxBits = 1;

  typedef logic [PosBits-1:0]   pos_t;
  typedef logic [OutBits-1:0]   out_pos_t;
  typedef logic [KindBits-1:0]  kind_t;
  typedef logic [CountBits-1:0] count_t;

  // Configuration register indexes
  localparam logic [CfgIdxBits-1:0] CfgStartOffset = 1'd0;
  localparam logic [CfgIdxBits-1:0] CfgHeadersOnly = 1'd1;

  // Record kinds
  localparam kind_t KindToken0   = 3'd0;
  localparam kind_t KindToken1   = 3'd1;
  localparam kind_t KindToken2   = 3'd2;
  localparam kind_t KindField    = 3'd3;
  localparam kind_t KindEnd      = 3'd4;
  localparam kind_t KindBadStart = 3'd5;

  // Characters of interest
  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChLf    = 8'h0A;
  localparam logic [7:0] ChColon = 8'h3A;
  localparam logic [7:0] ChSpace = 8'h20;

  // Classified byte as handed from the front end to the parser
  typedef struct packed {
    pos_t pos;       // position of this byte
    pos_t nxt;       // position after this byte
    logic active;    // position at or past the start offset
    logic first;     // restarts the message
    logic last;      // final byte of the buffer
    logic is_space;  // exactly a space
    logic is_ws;     // any byte up to and including a space
    logic is_cr;
    logic is_lf;
    logic is_colon;
  } entry_t;

endpackage

/* sv/hht_byte_if.sv */
// Byte input channel of the tokenizer.
interface hht_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_value;
  logic       first_of_message;
  logic       last_of_buffer;

  modport source (output valid, byte_value, first_of_message, last_of_buffer, input ready);
  modport sink   (input valid, byte_value, first_of_message, last_of_buffer, output ready);
endinterface

/* sv/hht_rec_if.sv */
// Record output channel of the tokenizer.
interface hht_rec_if;
  import hht_pkg::*;
  logic     valid;
  logic     ready;
  kind_t    record_kind;
  out_pos_t first_start;
  out_pos_t first_length;
  out_pos_t second_start;
  out_pos_t second_length;
  count_t   field_number;
  out_pos_t end_offset;

  modport source (output valid, record_kind, first_start, first_length, second_start,
                  second_length, field_number, end_offset, input ready);
  modport sink   (input valid, record_kind, first_start, first_length, second_start,
                  second_length, field_number, end_offset, output ready);
endinterface

/* sv/hht_cfg_if.sv */
// Configuration write channel of the tokenizer.
interface hht_cfg_if;
  import hht_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CfgIdxBits-1:0] index;
  logic [15:0]           data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* sv/http_header_tokenizer_core.sv */
// Top level of the HTTP header tokenizer: configuration registers and the front/back pipeline.
//
// Byte-serial HTTP header tokenizer. One byte is accepted per clock cycle while the queue
// is not full; the classifier tags each byte with its position, a two-entry queue decouples
// it from the parser, and the parser state machine takes one queued byte per cycle into a
// single result register while that register is free or being drained. The byte that
// completes a record passes through the queue before its record is registered. The parser
// state is registered from one byte to the next, which sets the rate of one byte per cycle
// as long as records are taken. Configuration is to be written through the cfg channel only
// while the block is idle, a rule the block does not enforce; the cfg channel is always ready.
module http_header_tokenizer_core
  import hht_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  hht_byte_if.sink  byte_i,
  hht_cfg_if.sink   cfg_i,
  hht_rec_if.source record_o
);

  logic [15:0] start_offset_q;
  logic        headers_only_q;
  logic        q_full, q_empty, push, pop;
  entry_t      push_entry, pop_entry;

  // Configuration registers
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_offset_q <= '0;
      headers_only_q <= 1'b0;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        CfgStartOffset: start_offset_q <= cfg_i.data;
        CfgHeadersOnly: headers_only_q <= cfg_i.data[0];
        default: ;
      endcase
    end
  end

  hht_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .byte_i         (byte_i),
    .start_offset_i (start_offset_q),
    .q_full_i       (q_full),
    .push_o         (push),
    .entry_o        (push_entry)
  );

  hht_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_entry),
    .full_o      (q_full),
    .pop_i       (pop),
    .empty_o     (q_empty),
    .pop_data_o  (pop_entry)
  );

  hht_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .headers_only_i (headers_only_q),
    .q_empty_i      (q_empty),
    .entry_i        (pop_entry),
    .pop_o          (pop),
    .rec_o          (record_o)
  );

endmodule

/* sv/hht_fifo.sv */
// Two-entry queue between the byte classifier and the parser.
module hht_fifo
  import hht_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  entry_t push_data_i,
  output logic   full_o,
  input  logic   pop_i,
  output logic   empty_o,
  output entry_t pop_data_o
);

  entry_t     mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;

  assign full_o     = (count_q == 2'd2);
  assign empty_o    = (count_q == 2'd0);
  assign pop_data_o = mem_q[rd_ptr_q];

  // Storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) wr_ptr_q <= ~wr_ptr_q;
      if (pop_i)  rd_ptr_q <= ~rd_ptr_q;
      if (push_i && !pop_i)      count_q <= count_q + 2'd1;
      else if (!push_i && pop_i) count_q <= count_q - 2'd1;
    end
  end

endmodule

/* sv/hht_front.sv */
// Front end: accepts bytes, counts positions and classifies each byte.
module hht_front
  import hht_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  hht_byte_if.sink      byte_i,
  input  logic [15:0]   start_offset_i,
  input  logic          q_full_i,
  output logic          push_o,
  output entry_t        entry_o
);

  pos_t pos_q;
  pos_t pos;
  pos_t nxt;
  logic [7:0] b;

  assign byte_i.ready = !q_full_i;
  assign push_o       = byte_i.valid && !q_full_i;
  assign b            = byte_i.byte_value;

  // Position of this byte restarts at zero with a new message
  assign pos = byte_i.first_of_message ? '0 : pos_q;
  assign nxt = pos + PosBits'(1);

  // Classification
  always_comb begin
    entry_o.pos      = pos;
    entry_o.nxt      = nxt;
    entry_o.active   = CmpBits'(pos) >= CmpBits'(start_offset_i);
    entry_o.first    = byte_i.first_of_message;
    entry_o.last     = byte_i.last_of_buffer;
    entry_o.is_space = (b == ChSpace);
    entry_o.is_ws    = (b <= ChSpace);
    entry_o.is_cr    = (b == ChCr);
    entry_o.is_lf    = (b == ChLf);
    entry_o.is_colon = (b == ChColon);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else if (push_o) begin
      pos_q <= nxt;
    end
  end

endmodule

/* sv/hht_back.sv */
// Back end: parser state machine and result register.
module hht_back
  import hht_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      headers_only_i,
  input  logic      q_empty_i,
  input  entry_t    entry_i,
  output logic      pop_o,
  hht_rec_if.source rec_o
);

  // Parser phases
  localparam logic [3:0] PhT0Skip   = 4'd0;
  localparam logic [3:0] PhT0Tok    = 4'd1;
  localparam logic [3:0] PhT1Skip   = 4'd2;
  localparam logic [3:0] PhT1Tok    = 4'd3;
  localparam logic [3:0] PhT2Skip   = 4'd4;
  localparam logic [3:0] PhT2Tok    = 4'd5;
  localparam logic [3:0] PhHdrStart = 4'd6;
  localparam logic [3:0] PhKey      = 4'd7;
  localparam logic [3:0] PhValSkip  = 4'd8;
  localparam logic [3:0] PhValue    = 4'd9;
  localparam logic [3:0] PhDone     = 4'd10;

  logic [3:0] phase_q, phase_d;
  pos_t   token_begin_q, token_begin_d;
  pos_t   line_begin_q, line_begin_d;
  pos_t   key_begin_q, key_begin_d;
  pos_t   key_size_q, key_size_d;
  pos_t   value_begin_q, value_begin_d;
  count_t header_count_q, header_count_d;
  logic   pending_cr_q, pending_cr_d;

  logic   out_valid_q;
  kind_t  kind_q, kind_d;
  pos_t   f_start_q, f_start_d, f_len_q, f_len_d;
  pos_t   s_start_q, s_start_d, s_len_q, s_len_d;
  pos_t   end_off_q, end_off_d;
  count_t fnum_q;
  logic   emit;

  // One entry per cycle whenever the queue is not empty and the result slot is free or being drained
  assign pop_o = !q_empty_i && (!out_valid_q || rec_o.ready);

  // Parser step
  always_comb begin
    logic [3:0] ph;
    ph             = phase_q;
    token_begin_d  = token_begin_q;
    line_begin_d   = line_begin_q;
    key_begin_d    = key_begin_q;
    key_size_d     = key_size_q;
    value_begin_d  = value_begin_q;
    header_count_d = header_count_q;
    pending_cr_d   = pending_cr_q;
    emit           = 1'b0;
    kind_d         = KindToken0;
    f_start_d      = '0;
    f_len_d        = '0;
    s_start_d      = '0;
    s_len_d        = '0;
    end_off_d      = '0;

    // New message restarts all parse state
    if (entry_i.first) begin
      ph             = headers_only_i ? PhHdrStart : PhT0Skip;
      token_begin_d  = '0;
      line_begin_d   = '0;
      key_begin_d    = '0;
      key_size_d     = '0;
      value_begin_d  = '0;
      header_count_d = '0;
      pending_cr_d   = 1'b0;
    end
    phase_d = ph;

    if (ph != PhDone) begin
      if (entry_i.active) begin
        case (ph)
          PhT0Skip, PhT1Skip, PhT2Skip: begin
            if (!entry_i.is_ws) begin
              token_begin_d = entry_i.pos;
              pending_cr_d  = 1'b0;
              phase_d       = ph + 4'd1;
            end
          end
          PhT0Tok, PhT1Tok: begin
            if (entry_i.is_space) begin
              emit      = 1'b1;
              kind_d    = (ph == PhT0Tok) ? KindToken0 : KindToken1;
              f_start_d = token_begin_d;
              f_len_d   = entry_i.pos - token_begin_d;
              phase_d   = ph + 4'd1;
            end
          end
          PhT2Tok: begin
            if (pending_cr_d && entry_i.is_lf) begin
              emit         = 1'b1;
              kind_d       = KindToken2;
              f_start_d    = token_begin_d;
              f_len_d      = entry_i.pos - PosBits'(1) - token_begin_d;
              pending_cr_d = 1'b0;
              phase_d      = PhHdrStart;
            end else begin
              pending_cr_d = entry_i.is_cr;
            end
          end
          PhHdrStart: begin
            // First key byte opens the line; stray CR and LF are skipped
            if (!entry_i.is_cr && !entry_i.is_lf) begin
              line_begin_d = entry_i.pos;
              key_begin_d  = entry_i.pos;
              pending_cr_d = 1'b0;
              if (entry_i.is_colon) begin
                key_size_d = '0;
                phase_d    = PhValSkip;
              end else begin
                phase_d = PhKey;
              end
            end
          end
          PhKey: begin
            if (entry_i.is_colon) begin
              key_size_d   = entry_i.pos - key_begin_d;
              pending_cr_d = 1'b0;
              phase_d      = PhValSkip;
            end else if (pending_cr_d && entry_i.is_lf) begin
              emit      = 1'b1;
              kind_d    = KindEnd;
              end_off_d = line_begin_d;
              phase_d   = PhDone;
            end else begin
              pending_cr_d = entry_i.is_cr;
            end
          end
          PhValSkip: begin
            if (entry_i.is_cr || !entry_i.is_ws) begin
              value_begin_d = entry_i.pos;
              pending_cr_d  = entry_i.is_cr;
              phase_d       = PhValue;
            end
          end
          PhValue: begin
            if (pending_cr_d && entry_i.is_lf) begin
              if (header_count_d != '1) header_count_d = header_count_d + CountBits'(1);
              emit         = 1'b1;
              kind_d       = KindField;
              f_start_d    = key_begin_d;
              f_len_d      = key_size_d;
              s_start_d    = value_begin_d;
              s_len_d      = entry_i.pos - PosBits'(1) - value_begin_d;
              pending_cr_d = 1'b0;
              line_begin_d = entry_i.nxt;
              key_begin_d  = entry_i.nxt;
              phase_d      = PhKey;
            end else begin
              pending_cr_d = entry_i.is_cr;
            end
          end
          default: begin
            phase_d = PhDone;
          end
        endcase
      end

      // Buffer end closes whatever is open
      if (entry_i.last && phase_d != PhDone) begin
        if (emit && (kind_d == KindToken2 || kind_d == KindField)) begin
          end_off_d = entry_i.nxt;
        end else begin
          emit      = 1'b1;
          f_start_d = '0;
          f_len_d   = '0;
          s_start_d = '0;
          s_len_d   = '0;
          if (phase_d <= PhT2Tok) begin
            kind_d    = KindBadStart;
            end_off_d = entry_i.nxt;
          end else begin
            kind_d    = KindEnd;
            end_off_d = (phase_d == PhHdrStart) ? entry_i.nxt : line_begin_d;
          end
        end
        phase_d = PhDone;
      end
    end
  end

  // Parser state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q        <= PhT0Skip;
      token_begin_q  <= '0;
      line_begin_q   <= '0;
      key_begin_q    <= '0;
      key_size_q     <= '0;
      value_begin_q  <= '0;
      header_count_q <= '0;
      pending_cr_q   <= 1'b0;
    end else if (pop_o) begin
      phase_q        <= phase_d;
      token_begin_q  <= token_begin_d;
      line_begin_q   <= line_begin_d;
      key_begin_q    <= key_begin_d;
      key_size_q     <= key_size_d;
      value_begin_q  <= value_begin_d;
      header_count_q <= header_count_d;
      pending_cr_q   <= pending_cr_d;
    end
  end

  // Result register: valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (pop_o) begin
      out_valid_q <= emit;
    end else if (rec_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  // Result register: payload
  always_ff @(posedge clk_i) begin
    if (pop_o && emit) begin
      kind_q    <= kind_d;
      f_start_q <= f_start_d;
      f_len_q   <= f_len_d;
      s_start_q <= s_start_d;
      s_len_q   <= s_len_d;
      end_off_q <= end_off_d;
      fnum_q    <= header_count_d;
    end
  end

  assign rec_o.valid         = out_valid_q;
  assign rec_o.record_kind   = kind_q;
  assign rec_o.first_start   = OutBits'(f_start_q);
  assign rec_o.first_length  = OutBits'(f_len_q);
  assign rec_o.second_start  = OutBits'(s_start_q);
  assign rec_o.second_length = OutBits'(s_len_q);
  assign rec_o.field_number  = fnum_q;
  assign rec_o.end_offset    = OutBits'(end_off_q);

endmodule
